>>> src/ddsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddsr_pkg
// Types and constants shared by the differential drive speed ramp.
// ----------------------------------------------------------------------------
package ddsr_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned VelW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned ProdW  = VelW + GainW + 1;

  localparam logic [SpeedW-1:0] STOP_SPEED = 8'd128;

  localparam logic [GainW-1:0]  SPEED_GAIN_RST = 16'd31903;
  localparam logic [GainW-1:0]  TURN_GAIN_RST  = 16'd4387;
  localparam logic [SpeedW-1:0] RAMP_STEP_RST  = 8'd5;

  typedef enum logic [0:0] {
    OP_COMMAND = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_SPEED_GAIN = 2'd0,
    CFG_TURN_GAIN  = 2'd1,
    CFG_RAMP_STEP  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t                    opcode;
    logic signed [VelW-1:0] linear_velocity;
    logic signed [VelW-1:0] angular_velocity;
  } in_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] wheel1_speed;
    logic [SpeedW-1:0] wheel2_speed;
  } out_item_t;

  typedef struct packed {
    logic [GainW-1:0]  speed_gain;
    logic [GainW-1:0]  turn_gain;
    logic [SpeedW-1:0] ramp_step;
  } cfg_t;

  // Products handed from the multiply stage to the ramp stage.
  typedef struct packed {
    logic                    valid;
    op_t                     opcode;
    logic signed [ProdW-1:0] lin_prod;
    logic signed [ProdW-1:0] ang_prod;
  } stage_t;

endpackage
`default_nettype wire

>>> src/ddsr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddsr_cfg
// Configuration registers: speed gain, turn gain and ramp step.
// ----------------------------------------------------------------------------
module ddsr_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [ddsr_pkg::GainW-1:0]  cfg_data,
  output ddsr_pkg::cfg_t                   cfg
);

  ddsr_pkg::cfg_t cfg_r;
  ddsr_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (ddsr_pkg::cfg_idx_t'(cfg_index))
        ddsr_pkg::CFG_SPEED_GAIN: cfg_nxt.speed_gain = cfg_data;
        ddsr_pkg::CFG_TURN_GAIN:  cfg_nxt.turn_gain  = cfg_data;
        ddsr_pkg::CFG_RAMP_STEP:  cfg_nxt.ramp_step  = cfg_data[ddsr_pkg::SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_gain <= ddsr_pkg::SPEED_GAIN_RST;
      cfg_r.turn_gain  <= ddsr_pkg::TURN_GAIN_RST;
      cfg_r.ramp_step  <= ddsr_pkg::RAMP_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/ddsr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddsr_mul
// Input register stage: takes a request and registers both gain products.
// ----------------------------------------------------------------------------
module ddsr_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ddsr_pkg::in_item_t in_data,
  input  wire ddsr_pkg::cfg_t     cfg,
  input  wire logic               go,
  output ddsr_pkg::stage_t        stage
);

  logic                                       valid_r;
  ddsr_pkg::op_t                              opcode_r;
  logic signed [ddsr_pkg::ProdW-1:0]          lin_prod_r;
  logic signed [ddsr_pkg::ProdW-1:0]          ang_prod_r;
  logic signed [ddsr_pkg::ProdW-1:0]          lin_prod_nxt;
  logic signed [ddsr_pkg::ProdW-1:0]          ang_prod_nxt;
  logic                                       load;

  assign in_stall = valid_r && !go;
  assign load     = in_valid && !in_stall;

  // Gains are unsigned, so they get a zero sign bit before the signed multiply.
  assign lin_prod_nxt = (ddsr_pkg::ProdW)'(in_data.linear_velocity)
                        * (ddsr_pkg::ProdW)'($signed({1'b0, cfg.speed_gain}));
  assign ang_prod_nxt = (ddsr_pkg::ProdW)'(in_data.angular_velocity)
                        * (ddsr_pkg::ProdW)'($signed({1'b0, cfg.turn_gain}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      opcode_r   <= in_data.opcode;
      lin_prod_r <= lin_prod_nxt;
      ang_prod_r <= ang_prod_nxt;
    end
  end

  assign stage.valid    = valid_r;
  assign stage.opcode   = opcode_r;
  assign stage.lin_prod = lin_prod_r;
  assign stage.ang_prod = ang_prod_r;

endmodule
`default_nettype wire

>>> src/ddsr_ramp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddsr_ramp
// Wheel targets, ramped wheel speeds and the result register.
// ----------------------------------------------------------------------------
module ddsr_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ddsr_pkg::stage_t            stage,
  input  wire logic [ddsr_pkg::SpeedW-1:0] ramp_step,
  output logic                             go,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ddsr_pkg::out_item_t              out_data
);

  localparam int unsigned SumW = ddsr_pkg::ProdW + 1;
  localparam int unsigned ShW  = SumW - 16;

  logic [ddsr_pkg::SpeedW-1:0] target_one_r, target_one_nxt;
  logic [ddsr_pkg::SpeedW-1:0] target_two_r, target_two_nxt;
  logic [ddsr_pkg::SpeedW-1:0] actual_one_r, actual_one_nxt;
  logic [ddsr_pkg::SpeedW-1:0] actual_two_r, actual_two_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ddsr_pkg::out_item_t         out_data_r;
  logic                        adv;
  logic                        is_cmd;
  logic signed [SumW-1:0]      diff_sum;
  logic signed [SumW-1:0]      plus_sum;

  // Floor of sum / 65536 plus the stop offset, clamped to a speed byte.
  function automatic logic [ddsr_pkg::SpeedW-1:0] make_target(
    input logic signed [SumW-1:0] sum
  );
    logic signed [ShW:0] t;
    t = {sum[SumW-1], sum[SumW-1:16]} + $signed({{(ShW-ddsr_pkg::SpeedW+1){1'b0}},
                                                 ddsr_pkg::STOP_SPEED});
    if (t < 0) begin
      return '0;
    end else if (t > $signed((ShW+1)'(255))) begin
      return '1;
    end
    return t[ddsr_pkg::SpeedW-1:0];
  endfunction

  // One step toward the target; a step at least as large as the gap lands on it.
  function automatic logic [ddsr_pkg::SpeedW-1:0] ramp(
    input logic [ddsr_pkg::SpeedW-1:0] actual,
    input logic [ddsr_pkg::SpeedW-1:0] target,
    input logic [ddsr_pkg::SpeedW-1:0] step
  );
    logic [ddsr_pkg::SpeedW-1:0] gap;
    gap = '0;
    if (actual < target) begin
      gap = target - actual;
      return (step >= gap) ? target : actual + step;
    end else if (actual > target) begin
      gap = actual - target;
      return (step >= gap) ? target : actual - step;
    end
    return actual;
  endfunction

  assign is_cmd = (stage.opcode == ddsr_pkg::OP_COMMAND);
  // A command produces no result, so it never waits on the result register.
  assign go     = is_cmd || !out_valid_r || !out_stall;
  assign adv    = stage.valid && go;

  assign diff_sum = SumW'(stage.lin_prod) - SumW'(stage.ang_prod);
  assign plus_sum = SumW'(stage.lin_prod) + SumW'(stage.ang_prod);

  always_comb begin
    target_one_nxt = target_one_r;
    target_two_nxt = target_two_r;
    actual_one_nxt = actual_one_r;
    actual_two_nxt = actual_two_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (adv) begin
      if (is_cmd) begin
        target_one_nxt = make_target(diff_sum);
        target_two_nxt = make_target(plus_sum);
      end else begin
        actual_one_nxt = ramp(actual_one_r, target_one_r, ramp_step);
        actual_two_nxt = ramp(actual_two_r, target_two_r, ramp_step);
        out_valid_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_one_r <= ddsr_pkg::STOP_SPEED;
      target_two_r <= ddsr_pkg::STOP_SPEED;
      actual_one_r <= ddsr_pkg::STOP_SPEED;
      actual_two_r <= ddsr_pkg::STOP_SPEED;
      out_valid_r  <= 1'b0;
    end else begin
      target_one_r <= target_one_nxt;
      target_two_r <= target_two_nxt;
      actual_one_r <= actual_one_nxt;
      actual_two_r <= actual_two_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !is_cmd) begin
      out_data_r.wheel1_speed <= actual_one_nxt;
      out_data_r.wheel2_speed <= actual_two_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_target_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && is_cmd) |=> $stable(target_one_r) && $stable(target_two_r))
    else $error("wheel target changed without a command");

  a_actual_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && !is_cmd) |=> $stable(actual_one_r) && $stable(actual_two_r))
    else $error("wheel speed changed without a tick");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_cmd) |=> out_valid_r && out_data_r.wheel1_speed == actual_one_r
                         && out_data_r.wheel2_speed == actual_two_r)
    else $error("tick did not load the result register");

  a_on_target: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_cmd && actual_one_r == target_one_r) |=> actual_one_r == $past(actual_one_r))
    else $error("wheel 1 moved away from its target");
`endif

endmodule
`default_nettype wire

>>> src/diff_drive_speed_ramp.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick request is registered first in the multiply stage, then in the
// result register once that register is free or being read.
// Throughput: one request per cycle unless the result register stalls a
// tick; commands never wait on the result register.
// Reset (synchronous, active low) clears both valid bits, sets all targets
// and wheel speeds to 128 and loads the default gains and ramp step.
// ----------------------------------------------------------------------------
// diff_drive_speed_ramp
// Two-wheel speed ramp: velocity commands set wheel targets, ticks move the
// wheel speeds toward them by at most the ramp step and report both speeds.
// ----------------------------------------------------------------------------
module diff_drive_speed_ramp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire ddsr_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output ddsr_pkg::out_item_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [ddsr_pkg::GainW-1:0] cfg_data
);

  ddsr_pkg::cfg_t   cfg;
  ddsr_pkg::stage_t stage;
  logic             go;

  ddsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ddsr_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .go       (go),
    .stage    (stage)
  );

  ddsr_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .ramp_step (cfg.ramp_step),
    .go        (go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-wheel speed ramp. Velocity commands and
// control ticks go in with random gaps, speed reports come out under random
// back-pressure, and each report is compared with the wheel speeds predicted
// from the same requests under the register settings in force.
// ----------------------------------------------------------------------------
module tb;

  localparam int          RunLimitNs     = 3_000_000;
  localparam int          DrainCycles    = 4;
  localparam int          EndWaitCycles  = 5000;
  localparam logic [1:0]  CfgIndexUnused = 2'd3;

  // Tracks targets and wheel speeds and holds the speed reports still owed.
  class wheel_speed_board;
    bit [ddsr_pkg::GainW-1:0]  speed_gain;
    bit [ddsr_pkg::GainW-1:0]  turn_gain;
    bit [ddsr_pkg::SpeedW-1:0] ramp_step;
    bit [ddsr_pkg::SpeedW-1:0] target_one, target_two;
    bit [ddsr_pkg::SpeedW-1:0] actual_one, actual_two;
    ddsr_pkg::out_item_t       expected_speeds[$];
    int unsigned               failures;
    int unsigned               reports_checked;

    function new();
      speed_gain = ddsr_pkg::SPEED_GAIN_RST;
      turn_gain  = ddsr_pkg::TURN_GAIN_RST;
      ramp_step  = ddsr_pkg::RAMP_STEP_RST;
      target_one = ddsr_pkg::STOP_SPEED;
      target_two = ddsr_pkg::STOP_SPEED;
      actual_one = ddsr_pkg::STOP_SPEED;
      actual_two = ddsr_pkg::STOP_SPEED;
    endfunction

    function void set_register(logic [1:0] index, logic [ddsr_pkg::GainW-1:0] value);
      case (index)
        ddsr_pkg::CFG_SPEED_GAIN: speed_gain = value;
        ddsr_pkg::CFG_TURN_GAIN:  turn_gain  = value;
        ddsr_pkg::CFG_RAMP_STEP:  ramp_step  = value[ddsr_pkg::SpeedW-1:0];
        default: ;
      endcase
    endfunction

    // Offset-128 target; the shift on a signed longint rounds toward minus infinity.
    function bit [ddsr_pkg::SpeedW-1:0] wheel_target(longint sum);
      longint t;
      t = longint'(ddsr_pkg::STOP_SPEED) + (sum >>> 16);
      if (t < 0) return '0;
      if (t > 255) return 8'd255;
      return 8'(t);
    endfunction

    function bit [ddsr_pkg::SpeedW-1:0] ramp_toward(bit [ddsr_pkg::SpeedW-1:0] actual,
                                                    bit [ddsr_pkg::SpeedW-1:0] target);
      int a, t, s;
      a = actual;
      t = target;
      s = ramp_step;
      if (a < t) return (a + s > t) ? target : 8'(a + s);
      if (a > t) return (a < t + s) ? target : 8'(a - s);
      return actual;
    endfunction

    function void note_request(ddsr_pkg::in_item_t req);
      longint              lin, ang;
      ddsr_pkg::out_item_t want;
      if (req.opcode == ddsr_pkg::OP_COMMAND) begin
        lin = longint'($signed(req.linear_velocity)) * longint'(speed_gain);
        ang = longint'($signed(req.angular_velocity)) * longint'(turn_gain);
        target_one = wheel_target(lin - ang);
        target_two = wheel_target(lin + ang);
      end else begin
        actual_one = ramp_toward(actual_one, target_one);
        actual_two = ramp_toward(actual_two, target_two);
        want.wheel1_speed = actual_one;
        want.wheel2_speed = actual_two;
        expected_speeds.push_back(want);
      end
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_speeds(ddsr_pkg::out_item_t got);
      ddsr_pkg::out_item_t want;
      reports_checked++;
      if (expected_speeds.size() == 0) begin
        flag($sformatf("unexpected speed report w1=%0d w2=%0d",
                       got.wheel1_speed, got.wheel2_speed));
        return;
      end
      want = expected_speeds.pop_front();
      if (got.wheel1_speed !== want.wheel1_speed || got.wheel2_speed !== want.wheel2_speed)
        flag($sformatf("speed mismatch: expected w1=%0d w2=%0d, got w1=%0d w2=%0d",
                       want.wheel1_speed, want.wheel2_speed,
                       got.wheel1_speed, got.wheel2_speed));
    endfunction

    function int unsigned pending();
      return expected_speeds.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  ddsr_pkg::in_item_t       in_data;
  logic                     out_valid;
  logic                     out_stall;
  ddsr_pkg::out_item_t      out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [ddsr_pkg::GainW-1:0] cfg_data;

  wheel_speed_board board;
  bit               quiet;
  bit               hold_off_req;
  int unsigned      hold_off_cycles;
  int unsigned      long_holds;
  int unsigned      requests_sent;
  int unsigned      settings_used;

  diff_drive_speed_ramp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_request(in_data);
      if (out_valid && !out_stall) board.check_speeds(out_data);
    end
  end

  // Receiver: random stall before each report, plus one long hold-off on request.
  initial begin
    int unsigned wait_cycles;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_req = 1'b0;
        long_holds++;
      end
      wait_cycles = quiet ? 0 : $urandom_range(0, 4);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #(RunLimitNs);
    $display("run limit reached with %0d speed reports outstanding", board.pending());
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic signed [ddsr_pkg::VelW-1:0] pick_velocity();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'(int'($urandom_range(0, 1023)) - 512);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 127)) - 64);
    endcase
  endfunction

  task automatic send_request(ddsr_pkg::in_item_t req);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic send_command(logic signed [ddsr_pkg::VelW-1:0] lin,
                              logic signed [ddsr_pkg::VelW-1:0] ang);
    ddsr_pkg::in_item_t req;
    req.opcode           = ddsr_pkg::OP_COMMAND;
    req.linear_velocity  = lin;
    req.angular_velocity = ang;
    send_request(req);
  endtask

  // The velocity fields of a tick are ignored, so they carry noise.
  task automatic send_tick();
    ddsr_pkg::in_item_t req;
    req.opcode           = ddsr_pkg::OP_TICK;
    req.linear_velocity  = 16'($urandom());
    req.angular_velocity = 16'($urandom());
    send_request(req);
  endtask

  task automatic write_register(logic [1:0] index, logic [ddsr_pkg::GainW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Commands leave no report behind, so a drain wait follows the last report.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned        first, ticks;
    ddsr_pkg::in_item_t req;
    first = requests_sent;
    while (requests_sent - first < count) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_command(pick_velocity(), pick_velocity());
        ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        repeat (ticks) send_tick();
      end else begin
        req.opcode           = ddsr_pkg::op_t'($urandom_range(0, 1));
        req.linear_velocity  = 16'($urandom());
        req.angular_velocity = 16'($urandom());
        send_request(req);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned sg, tg, rs, count;
    int unsigned guard;
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = ddsr_pkg::CFG_SPEED_GAIN;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: saturation both ways, pure turns, and negative
    // products that round down rather than toward zero.
    settings_used = 1;
    send_tick();
    send_command(16'sh7FFF, 16'sh0000);
    repeat (3) send_tick();
    send_command(16'sh8000, 16'sh0000);
    repeat (2) send_tick();
    send_command(16'sh0000, 16'sh7FFF);
    send_tick();
    send_command(16'sh0000, 16'sh8000);
    send_tick();
    send_command(16'sh0100, 16'sh0100);
    send_tick();
    send_command(-16'sd1, -16'sd1);
    send_tick();
    send_command(16'sh0000, 16'sh0000);
    send_tick();
    run_random(250);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin sg = 65535; tg = 65535; rs = 255; count = 150; end
        1: begin sg = 0;     tg = 65535; rs = 0;   count = 100; end
        2: begin sg = 65535; tg = 0;     rs = 1;   count = 150; end
        3: begin sg = 256;   tg = 256;   rs = 8;   count = 200; end
        4: begin
          sg = $urandom_range(0, 65535);
          tg = $urandom_range(0, 65535);
          rs = $urandom_range(1, 40);
          count = 200;
        end
        default: begin
          sg = $urandom_range(0, 2048);
          tg = $urandom_range(0, 2048);
          rs = $urandom_range(0, 255);
          count = 150;
        end
      endcase
      wait_idle();
      write_register(ddsr_pkg::CFG_SPEED_GAIN, 16'(sg));
      write_register(ddsr_pkg::CFG_TURN_GAIN, 16'(tg));
      // Bits above the step width must be dropped by the block.
      write_register(ddsr_pkg::CFG_RAMP_STEP, {8'($urandom_range(0, 255)), 8'(rs)});
      write_register(CfgIndexUnused, 16'($urandom()));
      settings_used++;

      send_command(16'sh7FFF, 16'sh8000);
      send_tick();
      send_command(16'sh8000, 16'sh7FFF);
      repeat (2) send_tick();

      if (p == 0) begin
        // Keep offering ticks while the receiver holds off, so the block backs up.
        send_command(pick_velocity(), pick_velocity());
        hold_off_cycles = $urandom_range(60, 100);
        hold_off_req    = 1'b1;
        quiet           = 1'b1;
        repeat (30) send_tick();
        quiet = 1'b0;
      end
      run_random(count);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < EndWaitCycles) begin
      @(posedge clk);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk);

    if (board.pending() != 0)
      $display("%0d speed reports never arrived", board.pending());
    $display("Covered %0d requests and %0d speed reports over %0d register settings,",
             requests_sent, board.reports_checked, settings_used);
    $display("with %0d long receiver hold-off(s) and %0d failure(s) seen.",
             long_holds, board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
